@@ rtl/ignition_presence_detector_unit_defines.svh @@
// Assertion helpers for the ignition presence detector.
`ifndef IGNITION_PRESENCE_DETECTOR_UNIT_DEFINES_SVH
`define IGNITION_PRESENCE_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define IPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipd assertion failed");

`endif

@@ rtl/ipd_pkg.sv @@
package ipd_pkg;

   localparam logic [1:0] SRC_NONE  = 2'd0;
   localparam logic [1:0] SRC_PIN   = 2'd1;
   localparam logic [1:0] SRC_PULSE = 2'd2;
   localparam logic [1:0] SRC_LEVEL = 2'd3;

   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_ON   = 2'd1;
   localparam logic [1:0] EV_OFF  = 2'd2;

   localparam logic [1:0] STEP_IDLE  = 2'd0;
   localparam logic [1:0] STEP_RISE  = 2'd1;
   localparam logic [1:0] STEP_ARMED = 2'd2;

   localparam logic [2:0] REG_SOURCE_SELECT = 3'd0;
   localparam logic [2:0] REG_WINDOW_LOW    = 3'd1;
   localparam logic [2:0] REG_WINDOW_HIGH   = 3'd2;
   localparam logic [2:0] REG_DROP_THRESH   = 3'd3;
   localparam logic [2:0] REG_RISE_THRESH   = 3'd4;
   localparam logic [2:0] REG_OFF_SWING     = 3'd5;
   localparam logic [2:0] REG_LEVEL_ON      = 3'd6;
   localparam logic [2:0] REG_LEVEL_OFF     = 3'd7;

   localparam int RING_DEPTH = 4;

   typedef logic [RING_DEPTH-1:0][15:0] ring_type;

   typedef struct packed {
      logic [15:0] window_low;
      logic [15:0] window_high;
      logic [15:0] drop_threshold;
      logic [15:0] rise_threshold;
      logic [15:0] off_swing_threshold;
      logic [15:0] level_on;
      logic [15:0] level_off;
   } cfg_type;

   // Voltage tracking state shared between top and the voltage update.
   typedef struct packed {
      logic [1:0]  source;
      logic [1:0]  step;
      logic [15:0] tick;
      logic [15:0] vmax;
      logic [15:0] vmin;
      logic [15:0] baseline;
      logic [1:0]  pos;
   } volt_state_type;

endpackage

@@ rtl/ignition_presence_detector_unit.sv @@
// Ignition presence detector.
// Input channel (req_*): one beat is one tick. req_kind 0 is a pin sample
// (req_pin_level, low means ignition active), 1 is a battery voltage sample
// (req_voltage). Result channel (rsp_*): exactly one beat per input beat, in
// order: the on/off event, whether the detection source switched, the source
// after the tick, and whether pulse detection is in progress.
// Configuration (csr_*): single-cycle writes, register index 0..7; write only
// while no beat is in flight. Writing source_select also reloads the source.
// The beat moves from the input register through the update logic into the result
// register, where rsp_valid rises; a stalled result register holds it back in the
// input register. Throughput: one beat per cycle while rsp_ready is high; the whole
// state update is one pass of compares and 16- and 18-bit adds between the input
// register and the result register.
// A stalled result holds in the result register while the input register
// takes one more beat; req_ready drops only when both are full and rsp_ready
// is low.
// Reset (synchronous, active high) empties both registers, loads the
// configuration defaults and clears all tracking state and the sample ring.
`include "ignition_presence_detector_unit_defines.svh"

module ignition_presence_detector_unit #(
   parameter int DEBOUNCE_STEPS  = 6,
   parameter int RISE_TICKS      = 50,
   parameter int OFF_CHECK_TICKS = 150
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic        req_pin_level,
   input  logic [15:0] req_voltage,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_res,
   output logic        rsp_source_changed,
   output logic [1:0]  rsp_source_now,
   output logic        rsp_checking,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int LVL_W = $clog2(DEBOUNCE_STEPS + 1);
   localparam logic [LVL_W-1:0] TOP = LVL_W'(DEBOUNCE_STEPS);

   // configuration
   ipd_pkg::cfg_type cfg_ff;

   // input register
   logic        in_valid_ff;
   logic        in_kind_ff;
   logic        in_pin_ff;
   logic [15:0] in_volt_ff;

   // tracking state
   logic [LVL_W-1:0]        debounce_level_ff;
   ipd_pkg::volt_state_type vst_ff;
   ipd_pkg::ring_type       ring_ff;

   // result register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_event_ff;
   logic        rsp_changed_ff;
   logic [1:0]  rsp_source_ff;
   logic        rsp_checking_ff;

   logic advance;

   // pin path
   logic [LVL_W-1:0] pin_level_in;
   logic [1:0]       pin_source;
   logic             pin_changed;
   logic [1:0]       pin_event;

   // voltage path
   ipd_pkg::volt_state_type vst_volt;
   ipd_pkg::ring_type       ring_volt;
   logic                    volt_changed;
   logic [1:0]              volt_event;

   ipd_pkg::volt_state_type vst_in;
   logic [1:0]              event_in;
   logic                    changed_in;

   ipd_pin_debounce #(
      .DEBOUNCE_STEPS(DEBOUNCE_STEPS),
      .LVL_W         (LVL_W)
   ) u_pin (
      .source    (vst_ff.source),
      .level     (debounce_level_ff),
      .pin_level (in_pin_ff),
      .level_nxt (pin_level_in),
      .source_nxt(pin_source),
      .changed   (pin_changed),
      .event_res (pin_event)
   );

   ipd_volt_track #(
      .RISE_TICKS     (RISE_TICKS),
      .OFF_CHECK_TICKS(OFF_CHECK_TICKS)
   ) u_volt (
      .cfg      (cfg_ff),
      .st       (vst_ff),
      .ring     (ring_ff),
      .voltage  (in_volt_ff),
      .st_nxt   (vst_volt),
      .ring_nxt (ring_volt),
      .changed  (volt_changed),
      .event_res(volt_event)
   );

   // the held beat moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      vst_in = vst_ff;
      if (in_kind_ff) begin
         vst_in     = vst_volt;
         event_in   = volt_event;
         changed_in = volt_changed;
      end else begin
         vst_in.source = pin_source;
         event_in      = pin_event;
         changed_in    = pin_changed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_low          <= 16'h0000;
         cfg_ff.window_high         <= 16'hFFFF;
         cfg_ff.drop_threshold      <= 16'h0000;
         cfg_ff.rise_threshold      <= 16'h0000;
         cfg_ff.off_swing_threshold <= 16'h0000;
         cfg_ff.level_on            <= 16'hFFFF;
         cfg_ff.level_off           <= 16'h0000;
         in_valid_ff                <= 1'b0;
         rsp_valid_ff               <= 1'b0;
         debounce_level_ff          <= '0;
         vst_ff                     <= '0;
         ring_ff                    <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
            in_kind_ff  <= req_kind;
            in_pin_ff   <= req_pin_level;
            in_volt_ff  <= req_voltage;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            rsp_event_ff    <= event_in;
            rsp_changed_ff  <= changed_in;
            rsp_source_ff   <= vst_in.source;
            rsp_checking_ff <= (vst_in.source == ipd_pkg::SRC_PULSE) &&
                               (vst_in.step != ipd_pkg::STEP_IDLE);
            vst_ff          <= vst_in;
            if (in_kind_ff) begin
               ring_ff <= ring_volt;
            end else begin
               debounce_level_ff <= pin_level_in;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            unique case (csr_index)
               ipd_pkg::REG_SOURCE_SELECT: vst_ff.source <= csr_wdata[1:0];
               ipd_pkg::REG_WINDOW_LOW:    cfg_ff.window_low <= csr_wdata;
               ipd_pkg::REG_WINDOW_HIGH:   cfg_ff.window_high <= csr_wdata;
               ipd_pkg::REG_DROP_THRESH:   cfg_ff.drop_threshold <= csr_wdata;
               ipd_pkg::REG_RISE_THRESH:   cfg_ff.rise_threshold <= csr_wdata;
               ipd_pkg::REG_OFF_SWING:     cfg_ff.off_swing_threshold <= csr_wdata;
               ipd_pkg::REG_LEVEL_ON:      cfg_ff.level_on <= csr_wdata;
               ipd_pkg::REG_LEVEL_OFF:     cfg_ff.level_off <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_event_ff;
   assign rsp_source_changed = rsp_changed_ff;
   assign rsp_source_now     = rsp_source_ff;
   assign rsp_checking       = rsp_checking_ff;

   `IPD_ASSERT_IMPLY(a_lvl_range, clock, reset, 1'b1, debounce_level_ff <= TOP)
   `IPD_ASSERT_IMPLY(a_step_code, clock, reset, 1'b1, vst_ff.step != 2'd3)
   `IPD_ASSERT_IMPLY(a_change_on, clock, reset, rsp_valid_ff && rsp_changed_ff,
                     rsp_event_ff == ipd_pkg::EV_ON)
   `IPD_ASSERT_IMPLY(a_check_src, clock, reset, rsp_valid_ff && rsp_checking_ff,
                     rsp_source_ff == ipd_pkg::SRC_PULSE)
   `IPD_ASSERT_IMPLY(a_full_stall, clock, reset, in_valid_ff && rsp_valid_ff && !rsp_ready,
                     !req_ready)

endmodule

@@ rtl/ipd_pin_debounce.sv @@
module ipd_pin_debounce #(
   parameter int DEBOUNCE_STEPS = 6,
   parameter int LVL_W          = 3
) (
   input  logic [1:0]       source,
   input  logic [LVL_W-1:0] level,
   input  logic             pin_level,
   output logic [LVL_W-1:0] level_nxt,
   output logic [1:0]       source_nxt,
   output logic             changed,
   output logic [1:0]       event_res
);

   localparam logic [LVL_W-1:0] TOP = LVL_W'(DEBOUNCE_STEPS);

   logic [LVL_W-1:0] lvl0;
   logic             moved;

   always_comb begin
      lvl0       = (level > TOP) ? '0 : level;
      level_nxt  = lvl0;
      source_nxt = source;
      changed    = 1'b0;
      event_res  = ipd_pkg::EV_NONE;
      moved      = 1'b0;
      if (source == ipd_pkg::SRC_NONE || source == ipd_pkg::SRC_PIN) begin
         // pin low means ignition active
         if (!pin_level && lvl0 != TOP) begin
            level_nxt = lvl0 + LVL_W'(1);
            moved     = 1'b1;
         end else if (pin_level && lvl0 != '0) begin
            level_nxt = lvl0 - LVL_W'(1);
            moved     = 1'b1;
         end
         if (moved && level_nxt == TOP) begin
            event_res = ipd_pkg::EV_ON;
            if (source != ipd_pkg::SRC_PIN) begin
               source_nxt = ipd_pkg::SRC_PIN;
               changed    = 1'b1;
            end
         end else if (moved && level_nxt == '0) begin
            event_res = ipd_pkg::EV_OFF;
         end
      end else begin
         level_nxt = level;
      end
   end

endmodule

@@ rtl/ipd_volt_track.sv @@
module ipd_volt_track #(
   parameter int RISE_TICKS      = 50,
   parameter int OFF_CHECK_TICKS = 150
) (
   input  ipd_pkg::cfg_type        cfg,
   input  ipd_pkg::volt_state_type st,
   input  ipd_pkg::ring_type       ring,
   input  logic [15:0]             voltage,
   output ipd_pkg::volt_state_type st_nxt,
   output ipd_pkg::ring_type       ring_nxt,
   output logic                    changed,
   output logic [1:0]              event_res
);

   // zero period acts as one
   localparam logic [15:0] RISE_P = ((RISE_TICKS % 65536) == 0) ? 16'd1 :
                                    16'(RISE_TICKS % 65536);
   localparam logic [15:0] OFF_P  = ((OFF_CHECK_TICKS % 65536) == 0) ? 16'd1 :
                                    16'(OFF_CHECK_TICKS % 65536);

   logic [1:0]  oldest;
   logic [15:0] swing_a;
   logic [15:0] swing_b;
   logic        armed;
   logic [1:0]  step_w;
   logic [15:0] base_w;
   logic [15:0] tick_inc;
   logic [17:0] sum;
   logic [15:0] avg;

   always_comb begin
      ring_nxt          = ring;
      ring_nxt[st.pos]  = voltage;
      oldest            = st.pos + 2'd1;
      st_nxt            = st;
      st_nxt.pos        = st.pos + 2'd1;
      changed           = 1'b0;
      event_res         = ipd_pkg::EV_NONE;
      if (voltage > st.vmax) st_nxt.vmax = voltage;
      if (voltage < st.vmin || st.vmin == 16'd0) st_nxt.vmin = voltage;

      sum = 18'(ring_nxt[0]) + 18'(ring_nxt[1]) + 18'(ring_nxt[2]) + 18'(ring_nxt[3]);
      avg = sum[17:2];

      swing_a  = (st_nxt.vmax >= st_nxt.vmin) ? st_nxt.vmax - st_nxt.vmin : 16'd0;
      armed    = (swing_a > cfg.drop_threshold) && (st.step == ipd_pkg::STEP_IDLE);
      step_w   = armed ? ipd_pkg::STEP_RISE : st.step;
      base_w   = armed ? ring[oldest] : st.baseline;
      tick_inc = (armed ? 16'd0 : st.tick) + 16'd1;
      swing_b  = swing_a;

      if (st.source == ipd_pkg::SRC_NONE || st.source == ipd_pkg::SRC_PULSE) begin
         if (voltage > cfg.window_high || voltage < cfg.window_low) begin
            // out of window: restart tracking, ring keeps the sample
            st_nxt.vmax     = '0;
            st_nxt.vmin     = '0;
            st_nxt.tick     = '0;
            st_nxt.pos      = '0;
            st_nxt.baseline = '0;
         end else begin
            if (armed) begin
               st_nxt.baseline = base_w;
               st_nxt.step     = ipd_pkg::STEP_RISE;
               st_nxt.vmax     = voltage;
               st_nxt.vmin     = voltage;
               st_nxt.tick     = '0;
            end
            case (step_w)
               ipd_pkg::STEP_RISE: begin
                  if (tick_inc >= RISE_P) begin
                     if (voltage > base_w && (voltage - base_w) > cfg.rise_threshold) begin
                        event_res   = ipd_pkg::EV_ON;
                        st_nxt.step = ipd_pkg::STEP_ARMED;
                        if (st.source != ipd_pkg::SRC_PULSE) begin
                           st_nxt.source = ipd_pkg::SRC_PULSE;
                           changed       = 1'b1;
                        end
                     end else begin
                        st_nxt.step = ipd_pkg::STEP_IDLE;
                     end
                     st_nxt.tick = '0;
                     st_nxt.vmax = voltage;
                     st_nxt.vmin = voltage;
                  end else begin
                     st_nxt.tick = tick_inc;
                  end
               end
               ipd_pkg::STEP_ARMED: begin
                  if (tick_inc >= OFF_P) begin
                     st_nxt.tick = '0;
                     if (swing_b >= cfg.off_swing_threshold) begin
                        event_res   = ipd_pkg::EV_OFF;
                        st_nxt.step = ipd_pkg::STEP_IDLE;
                        st_nxt.vmax = voltage;
                        st_nxt.vmin = voltage;
                     end
                  end else begin
                     st_nxt.tick = tick_inc;
                  end
               end
               default: begin
                  st_nxt.step = ipd_pkg::STEP_IDLE;
               end
            endcase
         end
      end else if (st.source == ipd_pkg::SRC_LEVEL) begin
         if (avg >= cfg.level_on) event_res = ipd_pkg::EV_ON;
         else if (avg < cfg.level_off) event_res = ipd_pkg::EV_OFF;
      end
   end

endmodule

@@ bench/ignition_presence_detector_checker.sv @@
module ignition_presence_detector_checker
   import ipd_pkg::*;
#(
   parameter int DEBOUNCE_STEPS  = 6,
   parameter int RISE_TICKS      = 50,
   parameter int OFF_CHECK_TICKS = 150
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic        req_pin_level,
   input  logic [15:0] req_voltage,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_event_res,
   input  logic        rsp_source_changed,
   input  logic [1:0]  rsp_source_now,
   input  logic        rsp_checking,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [1:0] event_res;
      logic       source_changed;
      logic [1:0] source_now;
      logic       checking;
   } ignition_report_t;

   localparam logic [3:0]  DEBOUNCE_TOP = 4'(DEBOUNCE_STEPS);
   // a period of zero counts as one
   localparam logic [15:0] RISE_PERIOD =
      (RISE_TICKS % 65536 == 0) ? 16'd1 : 16'(RISE_TICKS % 65536);
   localparam logic [15:0] OFF_PERIOD =
      (OFF_CHECK_TICKS % 65536 == 0) ? 16'd1 : 16'(OFF_CHECK_TICKS % 65536);

   cfg_type     cfg;
   logic [1:0]  source;
   logic [3:0]  debounce;
   logic [1:0]  detect;
   logic [15:0] tick_cnt;
   logic [15:0] vmax;
   logic [15:0] vmin;
   logic [15:0] baseline;
   ring_type    samples;
   logic [1:0]  ring_wr;
   logic        switched;

   ignition_report_t expected_reports[$];

   task automatic reset_model();
      cfg.window_low          = 16'h0000;
      cfg.window_high         = 16'hFFFF;
      cfg.drop_threshold      = 16'h0000;
      cfg.rise_threshold      = 16'h0000;
      cfg.off_swing_threshold = 16'h0000;
      cfg.level_on            = 16'hFFFF;
      cfg.level_off           = 16'h0000;
      source   = SRC_NONE;
      debounce = '0;
      detect   = STEP_IDLE;
      tick_cnt = '0;
      vmax     = '0;
      vmin     = '0;
      baseline = '0;
      samples  = '0;
      ring_wr  = '0;
   endtask

   task automatic apply_reg_write(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
         REG_SOURCE_SELECT: source = data[1:0];
         REG_WINDOW_LOW:    cfg.window_low = data;
         REG_WINDOW_HIGH:   cfg.window_high = data;
         REG_DROP_THRESH:   cfg.drop_threshold = data;
         REG_RISE_THRESH:   cfg.rise_threshold = data;
         REG_OFF_SWING:     cfg.off_swing_threshold = data;
         REG_LEVEL_ON:      cfg.level_on = data;
         REG_LEVEL_OFF:     cfg.level_off = data;
         default: ;
      endcase
   endtask

   function automatic bit advance_tick(input logic [15:0] period);
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= period) begin
         tick_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [1:0] pin_update(input logic pin);
      if (source != SRC_NONE && source != SRC_PIN)
         return EV_NONE;
      if (debounce > DEBOUNCE_TOP)
         debounce = '0;
      // pin low means ignition active
      if (!pin) begin
         if (debounce == DEBOUNCE_TOP)
            return EV_NONE;
         debounce = debounce + 4'd1;
      end else begin
         if (debounce == 4'd0)
            return EV_NONE;
         debounce = debounce - 4'd1;
      end
      if (debounce == DEBOUNCE_TOP) begin
         if (source != SRC_PIN) begin
            source   = SRC_PIN;
            switched = 1'b1;
         end
         return EV_ON;
      end
      return (debounce == 4'd0) ? EV_OFF : EV_NONE;
   endfunction

   function automatic logic [1:0] volt_update(input logic [15:0] v);
      logic [1:0]  oldest;
      logic [15:0] swing;
      logic [17:0] ring_sum;
      logic [1:0]  ev;
      ev = EV_NONE;
      samples[ring_wr] = v;
      oldest  = ring_wr + 2'd1;
      ring_wr = ring_wr + 2'd1;
      if (v > vmax)
         vmax = v;
      if (v < vmin || vmin == 16'd0)
         vmin = v;

      if (source == SRC_NONE || source == SRC_PULSE) begin
         if (v > cfg.window_high || v < cfg.window_low) begin
            // out of window: tracking restarts, ring keeps the sample
            vmax     = '0;
            vmin     = '0;
            tick_cnt = '0;
            ring_wr  = '0;
            baseline = '0;
            return EV_NONE;
         end
         swing = (vmax >= vmin) ? vmax - vmin : 16'd0;
         if (swing > cfg.drop_threshold && detect == STEP_IDLE) begin
            baseline = samples[oldest];
            detect   = STEP_RISE;
            vmax     = v;
            vmin     = v;
            tick_cnt = '0;
         end
         if (detect == STEP_RISE) begin
            if (advance_tick(RISE_PERIOD)) begin
               if (v > baseline && (v - baseline) > cfg.rise_threshold) begin
                  ev     = EV_ON;
                  detect = STEP_ARMED;
                  if (source != SRC_PULSE) begin
                     source   = SRC_PULSE;
                     switched = 1'b1;
                  end
               end else begin
                  detect = STEP_IDLE;
               end
               tick_cnt = '0;
               vmax     = v;
               vmin     = v;
            end
         end else if (detect == STEP_ARMED) begin
            if (advance_tick(OFF_PERIOD)) begin
               swing = (vmax >= vmin) ? vmax - vmin : 16'd0;
               if (swing >= cfg.off_swing_threshold) begin
                  ev       = EV_OFF;
                  detect   = STEP_IDLE;
                  tick_cnt = '0;
                  vmax     = v;
                  vmin     = v;
               end
            end
         end else begin
            detect = STEP_IDLE;
         end
      end else if (source == SRC_LEVEL) begin
         ring_sum = 18'(samples[0]) + 18'(samples[1]) + 18'(samples[2]) + 18'(samples[3]);
         if (ring_sum[17:2] >= cfg.level_on)
            ev = EV_ON;
         else if (ring_sum[17:2] < cfg.level_off)
            ev = EV_OFF;
      end
      return ev;
   endfunction

   function automatic ignition_report_t predict_tick(input logic kind, input logic pin,
                                                     input logic [15:0] volts);
      ignition_report_t r;
      switched = 1'b0;
      r.event_res      = kind ? volt_update(volts) : pin_update(pin);
      r.source_changed = switched;
      r.source_now     = source;
      r.checking       = (source == SRC_PULSE) && (detect != STEP_IDLE);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [1:0] want,
                              input logic [1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: rsp_%s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      ignition_report_t want;
      if (reset) begin
         reset_model();
         expected_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with none expected, got event %0d source %0d",
                        $time, rsp_event_res, rsp_source_now);
            end else begin
               want = expected_reports.pop_front();
               check_field("event_res", want.event_res, rsp_event_res);
               check_field("source_changed", want.source_changed, rsp_source_changed);
               check_field("source_now", want.source_now, rsp_source_now);
               check_field("checking", want.checking, rsp_checking);
            end
         end
         if (csr_we)
            apply_reg_write(csr_index, csr_wdata);
         if (req_valid && req_ready)
            expected_reports.push_back(predict_tick(req_kind, req_pin_level, req_voltage));
      end
      pending = expected_reports.size();
   end

endmodule

@@ bench/ignition_presence_detector_unit_test.sv @@
// Stimulus and verdict for the ignition presence detector. The checker beside
// the block predicts every result beat and compares it; this module only
// drives beats and rsp_ready, configures the block and decides pass or fail.
module ignition_presence_detector_unit_test;
   import ipd_pkg::*;

   localparam int DEBOUNCE_STEPS  = 6;
   localparam int RISE_TICKS      = 50;
   localparam int OFF_CHECK_TICKS = 150;
   localparam int RANDOM_BEATS    = 1300;
   localparam int LONG_HOLD       = 60;   // receiver stall in cycles

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic        req_pin_level;
   logic [15:0] req_voltage;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_event_res;
   logic        rsp_source_changed;
   logic [1:0]  rsp_source_now;
   logic        rsp_checking;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int checker_fails;
   int pending_reports;

   // idling plan, read by both the sender and the receiver
   int snd_idle_pct;
   int rsp_idle_pct;
   int items_sent;
   int random_end;
   // long receiver stalls: asked by the sender, served by the receiver
   int holds_asked;
   int holds_done;

   // config as last programmed, used to shape the beats
   cfg_type cfg_now;

   ignition_presence_detector_unit #(
      .DEBOUNCE_STEPS  (DEBOUNCE_STEPS),
      .RISE_TICKS      (RISE_TICKS),
      .OFF_CHECK_TICKS (OFF_CHECK_TICKS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_pin_level      (req_pin_level),
      .req_voltage        (req_voltage),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_source_changed (rsp_source_changed),
      .rsp_source_now     (rsp_source_now),
      .rsp_checking       (rsp_checking),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   ignition_presence_detector_checker #(
      .DEBOUNCE_STEPS  (DEBOUNCE_STEPS),
      .RISE_TICKS      (RISE_TICKS),
      .OFF_CHECK_TICKS (OFF_CHECK_TICKS)
   ) monitor (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_pin_level      (req_pin_level),
      .req_voltage        (req_voltage),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_source_changed (rsp_source_changed),
      .rsp_source_now     (rsp_source_now),
      .rsp_checking       (rsp_checking),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (checker_fails),
      .pending            (pending_reports)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: random ready at the falling edge, plus long stalls on request.
   // During a long stall the sender keeps offering, so the input and result
   // registers both fill and req_ready has to drop.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            rsp_ready <= 1'b0;
            for (int n = 1; n < LONG_HOLD; n++)
               @(negedge clock);
            holds_done++;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [15:0] clamp16(input int x);
      if (x < 0)
         return 16'h0000;
      if (x > 65535)
         return 16'hFFFF;
      return 16'(x);
   endfunction

   // Mostly a value in range, now and then one of the rails.
   function automatic logic [15:0] pick16(input int lo, input int hi);
      case ($urandom_range(0, 15))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic cfg_type default_cfg();
      cfg_type c;
      c.window_low          = 16'h0000;
      c.window_high         = 16'hFFFF;
      c.drop_threshold      = 16'h0000;
      c.rise_threshold      = 16'h0000;
      c.off_swing_threshold = 16'h0000;
      c.level_on            = 16'hFFFF;
      c.level_off           = 16'h0000;
      return c;
   endfunction

   // One input beat. Called at a falling edge, returns at a falling edge with
   // valid still high, so back-to-back beats never drop valid in between.
   task automatic feed(input logic kind, input logic pin, input logic [15:0] volts);
      // thirds: sender idles lightly and the receiver heavily, then the reverse, then nobody
      if (items_sent < 450) begin
         snd_idle_pct = 8;
         rsp_idle_pct = 56;
      end else if (items_sent < 900) begin
         snd_idle_pct = 56;
         rsp_idle_pct = 8;
      end else begin
         snd_idle_pct = 0;
         rsp_idle_pct = 0;
      end
      if (items_sent == 320 || items_sent == 1050)
         holds_asked++;
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_pin_level <= pin;
      req_voltage   <= volts;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic feed_volt(input int v);
      feed(1'b1, 1'($urandom), clamp16(v));
   endtask

   task automatic feed_pin(input logic pin);
      feed(1'b0, pin, 16'($urandom));
   endtask

   task automatic noise_tick();
      feed(1'($urandom), 1'($urandom), 16'($urandom));
   endtask

   // Stop offering and wait for every outstanding result beat. Every beat
   // yields a result, so an empty store means the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_reports != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic reconfigure(input logic [1:0] src, input cfg_type c);
      drain();
      write_reg(REG_WINDOW_LOW, c.window_low);
      write_reg(REG_WINDOW_HIGH, c.window_high);
      write_reg(REG_DROP_THRESH, c.drop_threshold);
      write_reg(REG_RISE_THRESH, c.rise_threshold);
      write_reg(REG_OFF_SWING, c.off_swing_threshold);
      write_reg(REG_LEVEL_ON, c.level_on);
      write_reg(REG_LEVEL_OFF, c.level_off);
      // upper bits are don't-care for the source register
      write_reg(REG_SOURCE_SELECT, {14'($urandom), src});
      csr_we <= 1'b0;
      cfg_now = c;
   endtask

   // A full pulse cycle: steady, a dip that arms, a ramp that is checked after
   // the rise period, then a stretch that is quiet or swings enough for off.
   task automatic pulse_cycle();
      int lo;
      int hi;
      int base;
      int dip;
      int peak;
      int amp;
      lo = cfg_now.window_low;
      hi = cfg_now.window_high;
      if (lo > hi) begin
         lo = 0;
         hi = 65535;
      end
      base = lo + (hi - lo) / 4 + int'($urandom_range(0, (hi - lo) / 2));
      repeat (4)
         feed_volt(base + int'($urandom_range(0, 40)) - 20);
      dip = base - int'(cfg_now.drop_threshold) - 1 - int'($urandom_range(0, 400));
      feed_volt(dip);
      // mostly a rise that clears the threshold, sometimes one that falls short
      if ($urandom_range(0, 3) != 0)
         peak = base + int'(cfg_now.rise_threshold) + 1 + int'($urandom_range(0, 300));
      else
         peak = base + int'($urandom_range(0, cfg_now.rise_threshold));
      for (int n = 1; n <= 55; n++) begin
         if ($urandom_range(0, 19) == 0)
            feed_pin(1'($urandom));
         feed_volt(n < 40 ? dip + (peak - dip) * n / 40 : peak);
      end
      if ($urandom_range(0, 1) != 0)
         amp = int'(cfg_now.off_swing_threshold) / 3;
      else
         amp = int'(cfg_now.off_swing_threshold) / 2 + int'($urandom_range(0, 500)) + 1;
      repeat (160) begin
         if ($urandom_range(0, 29) == 0)
            noise_tick();
         feed_volt(peak + int'($urandom_range(0, 2 * amp)) - amp);
      end
   endtask

   task automatic pin_burst();
      logic pin;
      pin = 1'($urandom);
      repeat ($urandom_range(1, 9))
         feed_pin(pin);
   endtask

   // Voltages around the level thresholds so the ring average crosses both.
   task automatic level_run();
      int mark;
      repeat (12) begin
         mark = ($urandom_range(0, 1) != 0) ? int'(cfg_now.level_on)
                                             : int'(cfg_now.level_off);
         feed_volt(mark + int'($urandom_range(0, 3000)) - 1500);
      end
   endtask

   task automatic random_segment();
      logic [1:0] src;
      cfg_type    c;
      int         start;
      case ($urandom_range(0, 5))
         0, 1:    src = SRC_PULSE;
         2:       src = SRC_NONE;
         3:       src = SRC_PIN;
         4:       src = SRC_LEVEL;
         default: src = 2'($urandom);
      endcase
      c.window_low          = pick16(0, 8000);
      c.window_high         = pick16(50000, 65535);
      c.drop_threshold      = pick16(50, 3000);
      c.rise_threshold      = pick16(0, 4000);
      c.off_swing_threshold = pick16(100, 6000);
      c.level_off           = pick16(2000, 30000);
      c.level_on            = pick16(int'(c.level_off), 60000);
      reconfigure(src, c);
      start = items_sent;
      while (items_sent - start < 200 && items_sent < random_end) begin
         if ($urandom_range(0, 9) == 0) begin
            noise_tick();
         end else begin
            case (src)
               SRC_PIN: pin_burst();
               SRC_LEVEL: begin
                  if ($urandom_range(0, 3) == 0)
                     pin_burst();
                  else
                     level_run();
               end
               SRC_NONE: begin
                  if ($urandom_range(0, 2) == 0)
                     pin_burst();
                  else
                     pulse_cycle();
               end
               default: pulse_cycle();
            endcase
         end
      end
   endtask

   initial begin
      cfg_type c;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = 1'b0;
      req_pin_level = 1'b1;
      req_voltage   = 16'h0000;
      csr_we        = 1'b0;
      csr_index     = REG_SOURCE_SELECT;
      csr_wdata     = 16'h0000;
      snd_idle_pct  = 0;
      rsp_idle_pct  = 0;
      items_sent    = 0;
      holds_asked   = 0;
      holds_done    = 0;
      cfg_now       = default_cfg();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset config (source none). Inactive pin at the zero rail,
      // debounce up to on (source switches to pin), active pin at the top rail.
      feed_pin(1'b1);
      repeat (DEBOUNCE_STEPS) feed_pin(1'b0);
      feed_pin(1'b0);
      // voltage beats under pin source only feed the ring and min/max
      feed_volt(65535);
      feed_volt(0);
      repeat (DEBOUNCE_STEPS) feed_pin(1'b1);

      // level mode with the thresholds at the rails
      c = default_cfg();
      c.level_on = 16'h0000;
      reconfigure(SRC_LEVEL, c);
      feed_volt(65535);
      c.level_on  = 16'hFFFF;
      c.level_off = 16'hFFFF;
      reconfigure(SRC_LEVEL, c);
      feed_volt(0);
      feed_pin(1'b0);   // ignored under a voltage source
      feed_volt(65535);

      // pulse mode with a narrow window: below, above, inside
      c = default_cfg();
      c.window_low  = 16'd100;
      c.window_high = 16'd200;
      reconfigure(SRC_PULSE, c);
      feed_volt(50);
      feed_volt(300);
      feed_volt(150);

      // random segments, each with its own config
      random_end = items_sent + RANDOM_BEATS;
      while (items_sent < random_end)
         random_segment();

      drain();
      repeat (8) @(negedge clock);
      if (checker_fails == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ipd_pkg.sv
rtl/ipd_pin_debounce.sv
rtl/ipd_volt_track.sv
rtl/ignition_presence_detector_unit.sv
bench/ignition_presence_detector_checker.sv
bench/ignition_presence_detector_unit_test.sv
